>>> src/mhp_pkg.sv
// Package for the message header parser: payload structs, parse phases,
// field kinds, error codes and the per-phase field length table.
// No dependencies; every module of the parser imports it.
`timescale 1ns / 1ps

package mhp_pkg;

   typedef enum logic [4:0] {
      PH_MSGFLAGS = 5'd0,
      PH_SESSION  = 5'd1,
      PH_SECFLAGS = 5'd2,
      PH_COUNTER  = 5'd3,
      PH_SRC      = 5'd4,
      PH_DSTNODE  = 5'd5,
      PH_DSTGROUP = 5'd6,
      PH_EXTLEN   = 5'd7,
      PH_EXTSKIP  = 5'd8,
      PH_XFLAGS   = 5'd9,
      PH_OPCODE   = 5'd10,
      PH_XID      = 5'd11,
      PH_PROTO    = 5'd12,
      PH_VENDOR   = 5'd13,
      PH_ACK      = 5'd14,
      PH_SKIP     = 5'd15
   } phase_type;

   localparam logic [3:0] KIND_MSGFLAGS = 4'd0;
   localparam logic [3:0] KIND_SESSION  = 4'd1;
   localparam logic [3:0] KIND_SECFLAGS = 4'd2;
   localparam logic [3:0] KIND_COUNTER  = 4'd3;
   localparam logic [3:0] KIND_SRC      = 4'd4;
   localparam logic [3:0] KIND_DSTNODE  = 4'd5;
   localparam logic [3:0] KIND_DSTGROUP = 4'd6;
   localparam logic [3:0] KIND_XFLAGS   = 4'd7;
   localparam logic [3:0] KIND_OPCODE   = 4'd8;
   localparam logic [3:0] KIND_XID      = 4'd9;
   localparam logic [3:0] KIND_PROTO    = 4'd10;
   localparam logic [3:0] KIND_VENDOR   = 4'd11;
   localparam logic [3:0] KIND_ACK      = 4'd12;
   localparam logic [3:0] KIND_DONE     = 4'd13;
   localparam logic [3:0] KIND_ERROR    = 4'd14;

   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_SHORT   = 2'd1;
   localparam logic [1:0] ERR_VERSION = 2'd2;

   localparam logic [1:0] DST_NODE  = 2'd1;
   localparam logic [1:0] DST_GROUP = 2'd2;

   localparam logic [7:0] MSG_SRC_BIT    = 8'h04;
   localparam logic [7:0] SEC_EXT_BIT    = 8'h20;
   localparam logic [7:0] XCH_VENDOR_BIT = 8'h10;
   localparam logic [7:0] XCH_ACK_BIT    = 8'h02;

   localparam logic [16:0] POS_MAX = 17'h1FFFF;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [3:0]  field_kind;
      logic [63:0] field_value;
      logic [1:0]  error_code;
      logic        last_of_run;
   } rsp_type;

   // Results caused by one byte: at most two, in order.
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } parse_out_type;

   function automatic logic [3:0] phase_len(input phase_type ph);
      logic [3:0] len;
      case (ph)
         PH_MSGFLAGS: len = 4'd1;
         PH_SESSION:  len = 4'd2;
         PH_SECFLAGS: len = 4'd1;
         PH_COUNTER:  len = 4'd4;
         PH_SRC:      len = 4'd8;
         PH_DSTNODE:  len = 4'd8;
         PH_DSTGROUP: len = 4'd2;
         PH_EXTLEN:   len = 4'd2;
         PH_XFLAGS:   len = 4'd1;
         PH_OPCODE:   len = 4'd1;
         PH_XID:      len = 4'd2;
         PH_PROTO:    len = 4'd2;
         PH_VENDOR:   len = 4'd2;
         PH_ACK:      len = 4'd4;
         default:     len = 4'd1;
      endcase
      return len;
   endfunction

endpackage

>>> src/mhp_parse_core.sv
// Parser state and the single-pass byte update: field assembly, phase
// sequencing and the up to two results a byte produces.
// Depends on mhp_pkg.
`timescale 1ns / 1ps

module mhp_parse_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  mhp_pkg::req_type       item,
   output mhp_pkg::parse_out_type pout
);
   import mhp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [3:0]  bif_ff, bif_in;
   logic [63:0] shift_ff, shift_in;
   logic [7:0]  mflags_ff, mflags_in;
   logic [7:0]  sflags_ff, sflags_in;
   logic [7:0]  xflags_ff, xflags_in;
   logic [15:0] ext_ff, ext_in;
   logic [16:0] pos_ff, pos_in;

   logic [63:0] shift_acc;
   logic [3:0]  bif_acc;
   logic [15:0] ext_dec;
   logic        field_step;
   phase_type   after_dst, after_src;
   rsp_type     e1, e2, e3, done_rsp;
   logic        v1, v2, v3;

   always_comb begin
      after_dst = ((sflags_ff & SEC_EXT_BIT) != 8'h00) ? PH_EXTLEN : PH_XFLAGS;
      case (mflags_ff[1:0])
         DST_NODE:  after_src = PH_DSTNODE;
         DST_GROUP: after_src = PH_DSTGROUP;
         default:   after_src = after_dst;
      endcase
   end

   always_comb begin
      pos_in    = (pos_ff != POS_MAX) ? pos_ff + 17'd1 : pos_ff;
      phase_in  = phase_ff;
      bif_in    = bif_ff;
      shift_in  = shift_ff;
      mflags_in = mflags_ff;
      sflags_in = sflags_ff;
      xflags_in = xflags_ff;
      ext_in    = ext_ff;
      e1 = '0;
      e2 = '0;
      e3 = '0;
      v1 = 1'b0;
      v2 = 1'b0;
      v3 = 1'b0;
      done_rsp = '0;
      done_rsp.field_kind  = KIND_DONE;
      done_rsp.field_value = {47'd0, pos_in};

      shift_acc = shift_ff;
      shift_acc[{bif_ff[2:0], 3'b000} +: 8] =
         shift_ff[{bif_ff[2:0], 3'b000} +: 8] | item.data_byte;
      bif_acc = {1'b0, bif_ff[2:0]} + 4'd1;
      ext_dec = (ext_ff != 16'd0) ? ext_ff - 16'd1 : ext_ff;
      field_step = (phase_ff <= PH_ACK) && (phase_ff != PH_EXTSKIP);

      if (phase_ff == PH_EXTSKIP) begin
         ext_in = ext_dec;
         if (ext_dec == 16'd0) begin
            phase_in = PH_XFLAGS;
         end
      end else if (field_step) begin
         shift_in = shift_acc;
         bif_in   = bif_acc;
         if (bif_acc >= phase_len(phase_ff)) begin
            shift_in = '0;
            bif_in   = '0;
            e1.field_value = shift_acc;
            e1.error_code  = ERR_NONE;
            v1 = 1'b1;
            case (phase_ff)
               PH_MSGFLAGS: begin
                  mflags_in     = shift_acc[7:0];
                  e1.field_kind = KIND_MSGFLAGS;
                  phase_in      = PH_SESSION;
               end
               PH_SESSION: begin
                  e1.field_kind = KIND_SESSION;
                  phase_in      = PH_SECFLAGS;
               end
               PH_SECFLAGS: begin
                  sflags_in     = shift_acc[7:0];
                  e1.field_kind = KIND_SECFLAGS;
                  phase_in      = PH_COUNTER;
               end
               PH_COUNTER: begin
                  e1.field_kind = KIND_COUNTER;
                  if (mflags_ff[7:4] != 4'd0) begin
                     e2.field_kind = KIND_ERROR;
                     e2.error_code = ERR_VERSION;
                     v2       = 1'b1;
                     phase_in = PH_SKIP;
                  end else if ((mflags_ff & MSG_SRC_BIT) != 8'h00) begin
                     phase_in = PH_SRC;
                  end else begin
                     phase_in = after_src;
                  end
               end
               PH_SRC: begin
                  e1.field_kind = KIND_SRC;
                  phase_in      = after_src;
               end
               PH_DSTNODE: begin
                  e1.field_kind = KIND_DSTNODE;
                  phase_in      = after_dst;
               end
               PH_DSTGROUP: begin
                  e1.field_kind = KIND_DSTGROUP;
                  phase_in      = after_dst;
               end
               PH_EXTLEN: begin
                  // The extension length itself produces no result.
                  v1       = 1'b0;
                  ext_in   = shift_acc[15:0];
                  phase_in = (shift_acc[15:0] != 16'd0) ? PH_EXTSKIP : PH_XFLAGS;
               end
               PH_XFLAGS: begin
                  xflags_in     = shift_acc[7:0];
                  e1.field_kind = KIND_XFLAGS;
                  phase_in      = PH_OPCODE;
               end
               PH_OPCODE: begin
                  e1.field_kind = KIND_OPCODE;
                  phase_in      = PH_XID;
               end
               PH_XID: begin
                  e1.field_kind = KIND_XID;
                  phase_in      = PH_PROTO;
               end
               PH_PROTO: begin
                  e1.field_kind = KIND_PROTO;
                  if ((xflags_ff & XCH_VENDOR_BIT) != 8'h00) begin
                     phase_in = PH_VENDOR;
                  end else if ((xflags_ff & XCH_ACK_BIT) != 8'h00) begin
                     phase_in = PH_ACK;
                  end else begin
                     e2       = done_rsp;
                     v2       = 1'b1;
                     phase_in = PH_SKIP;
                  end
               end
               PH_VENDOR: begin
                  e1.field_kind = KIND_VENDOR;
                  if ((xflags_ff & XCH_ACK_BIT) != 8'h00) begin
                     phase_in = PH_ACK;
                  end else begin
                     e2       = done_rsp;
                     v2       = 1'b1;
                     phase_in = PH_SKIP;
                  end
               end
               PH_ACK: begin
                  e1.field_kind = KIND_ACK;
                  e2       = done_rsp;
                  v2       = 1'b1;
                  phase_in = PH_SKIP;
               end
               default: begin
                  v1       = 1'b0;
                  phase_in = PH_SKIP;
               end
            endcase
         end
      end else begin
         phase_in = PH_SKIP;
      end

      // Any final byte rearms the parser; an unfinished header is an error.
      if (item.last_byte) begin
         v3 = (phase_in != PH_SKIP);
         e3.field_kind = KIND_ERROR;
         e3.error_code = ERR_SHORT;
         phase_in  = PH_MSGFLAGS;
         bif_in    = '0;
         shift_in  = '0;
         mflags_in = '0;
         sflags_in = '0;
         xflags_in = '0;
         ext_in    = '0;
         pos_in    = '0;
      end
   end

   // A second result from a completed field always moves the phase to skip,
   // so the truncation error never needs a third slot.
   always_comb begin
      pout.count  = {1'b0, v1} + {1'b0, v2} + {1'b0, v3};
      pout.first  = v1 ? e1 : e3;
      pout.second = v2 ? e2 : e3;
      pout.first.last_of_run  = (pout.count == 2'd1);
      pout.second.last_of_run = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_MSGFLAGS;
         bif_ff    <= '0;
         shift_ff  <= '0;
         mflags_ff <= '0;
         sflags_ff <= '0;
         xflags_ff <= '0;
         ext_ff    <= '0;
         pos_ff    <= '0;
      end else if (fire) begin
         phase_ff  <= phase_in;
         bif_ff    <= bif_in;
         shift_ff  <= shift_in;
         mflags_ff <= mflags_in;
         sflags_ff <= sflags_in;
         xflags_ff <= xflags_in;
         ext_ff    <= ext_in;
         pos_ff    <= pos_in;
      end
   end

endmodule

>>> src/mhp_rsp_fifo.sv
// Result queue: takes up to two results per cycle from the parser and
// hands them out one per cycle on the result channel while rsp_stall is low.
// Depends on mhp_pkg.
`timescale 1ns / 1ps

module mhp_rsp_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic [1:0]       push_n,
   input  mhp_pkg::rsp_type push_a,
   input  mhp_pkg::rsp_type push_b,
   output logic             room,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mhp_pkg::rsp_type rsp_payload
);
   import mhp_pkg::*;

   rsp_type                 entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wptr_ff, wptr_in;
   logic [FIFO_PTR_W-1:0]   rptr_ff, rptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;
   logic                    pop;

   assign rsp_valid   = (count_ff != '0);
   assign rsp_payload = entry_ff[rptr_ff];
   assign pop         = rsp_valid && !rsp_stall;
   // Room for the worst case of two results from one byte.
   assign room        = (count_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2));

   always_comb begin
      wptr_in  = wptr_ff + FIFO_PTR_W'(push_n);
      rptr_in  = rptr_ff + FIFO_PTR_W'(pop);
      count_in = count_ff + FIFO_CNT_W'(push_n) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         entry_ff[wptr_ff] <= push_a;
      end
      if (push_n == 2'd2) begin
         entry_ff[wptr_ff + FIFO_PTR_W'(1)] <= push_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> src/message_header_parser.sv
// Top level of the message header parser: input register, parse core and
// result queue. Depends on mhp_pkg, mhp_parse_core and mhp_rsp_fifo.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+------------------------
//   req_     | in        | req_valid / req_stall | req_payload (req_type)
//   rsp_     | out       | rsp_valid / rsp_stall | rsp_payload (rsp_type)
//
// One packet byte is taken per cycle while req_stall is low. A byte is
// registered, parsed from the input register and its results enter a
// four-entry queue, which drives rsp_valid. A byte that completes two
// results hands them out as two separate transactions. Reset returns the
// parser to the start of a packet and empties the queue. When the queue
// cannot take two more results, the registered byte waits and req_stall is
// raised.
`timescale 1ns / 1ps

module message_header_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mhp_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mhp_pkg::rsp_type rsp_payload
);
   import mhp_pkg::*;

   req_type       in_ff;
   logic          in_valid_ff, in_valid_in;
   logic          room;
   logic          proc_fire;
   logic          req_fire;
   logic [1:0]    push_n;
   parse_out_type pout;

   assign proc_fire   = in_valid_ff && room;
   assign req_stall   = in_valid_ff && !room;
   assign req_fire    = req_valid && !req_stall;
   assign in_valid_in = req_fire || (in_valid_ff && !proc_fire);
   assign push_n      = proc_fire ? pout.count : 2'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_ff <= req_payload;
      end
   end

   mhp_parse_core u_core (
      .clock (clock),
      .reset (reset),
      .fire  (proc_fire),
      .item  (in_ff),
      .pout  (pout)
   );

   mhp_rsp_fifo u_fifo (
      .clock       (clock),
      .reset       (reset),
      .push_n      (push_n),
      .push_a      (pout.first),
      .push_b      (pout.second),
      .room        (room),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
